### hdl/bglq_pkg.sv
// ----------------------------------------------------------------------------
// Balanced grey-level quantizer package
// Payload types, divider command types, state encoding and fixed widths
// shared by the quantizer and its divider.
// ----------------------------------------------------------------------------
package bglq_pkg;

   localparam int MAX_LEVELS     = 64;
   localparam int INDEX_BITS     = 24;
   localparam int GREY_BITS      = 16;
   localparam int LEVEL_BITS     = 6;
   localparam int LCOUNT_BITS    = 7;
   localparam int PIXEL_BITS     = 25;
   localparam int CSR_INDEX_BITS = 4;
   localparam int DIV_STEPS      = PIXEL_BITS;
   localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS + 1);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEVEL_COUNT  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_PIXELS = CSR_INDEX_BITS'(1);

   typedef struct packed {
      logic [INDEX_BITS-1:0] pixel_index;
      logic [GREY_BITS-1:0]  grey_value;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]  out_index;
      logic [LEVEL_BITS-1:0]  level;
      logic                   frame_done;
      logic [LCOUNT_BITS-1:0] levels_used;
   } rsp_type;

   typedef struct packed {
      logic                   start;
      logic [PIXEL_BITS-1:0]  dividend;
      logic [LCOUNT_BITS-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                  done;
      logic [PIXEL_BITS-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_CLOSE_WAIT,
      ST_CFG_START,
      ST_CFG_WAIT
   } state_type;

endpackage

### hdl/bglq_divider.sv
// ----------------------------------------------------------------------------
// Quota divider
// Restoring divider that produces one quotient bit per cycle. A start
// command loads new operands at any time and abandons a division in flight.
// ----------------------------------------------------------------------------
module bglq_divider
   import bglq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type div_cmd,
   output div_rsp_type div_rsp
);

   logic [PIXEL_BITS-1:0]   work_ff, work_in;
   logic [LCOUNT_BITS-1:0]  rem_ff, rem_in;
   logic [LCOUNT_BITS-1:0]  divisor_ff, divisor_in;
   logic [DIV_CNT_BITS-1:0] count_ff, count_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [LCOUNT_BITS:0]    trial;
   logic                    fits;

   always_comb begin
      trial = {rem_ff, work_ff[PIXEL_BITS-1]};
      fits  = trial >= {1'b0, divisor_ff};
   end

   always_comb begin
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (div_cmd.start) begin
         work_in    = div_cmd.dividend;
         rem_in     = '0;
         divisor_in = div_cmd.divisor;
         count_in   = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         work_in  = {work_ff[PIXEL_BITS-2:0], fits};
         rem_in   = fits ? LCOUNT_BITS'(trial - {1'b0, divisor_ff})
                         : LCOUNT_BITS'(trial);
         count_in = count_ff + DIV_CNT_BITS'(1);
         if (count_ff == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = work_ff;

`ifndef SYNTH
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_cmd.start |=> busy_ff)
      else $error("divider not busy after start");
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> count_ff < DIV_CNT_BITS'(DIV_STEPS))
      else $error("divider step count out of range");
`endif

endmodule

### hdl/balanced_grey_level_quantizer.sv
// ----------------------------------------------------------------------------
// Balanced grey-level quantizer
// Labels grey-sorted pixels with levels of near equal pixel count, never
// splitting one grey value across two levels. Level quotas come from a
// shared bit-serial divider run by a small sequencer.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_data  (pixel_index, grey_value)
//   rsp      out        rsp_valid/rsp_stall  rsp_data  (out_index, level, ...)
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// A pixel that stays in its level passes from the item registers through
// ST_EVAL to the result register. Each level closed on a pixel runs the
// divider for its 25 steps in ST_CLOSE_WAIT to get the new quota. A register
// write restarts the frame and computes the first quota in ST_CFG_START and
// ST_CFG_WAIT, with req_stall high meanwhile. Reset gives one level over a
// one-pixel frame. The result register frees the input side while a result
// waits; rsp_stall holds the sequencer only when a second result is ready.
// ----------------------------------------------------------------------------
module balanced_grey_level_quantizer
   import bglq_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [PIXEL_BITS-1:0]     csr_data
);

   state_type state_ff, state_in;

   logic [LCOUNT_BITS-1:0] level_count_ff, level_count_in;
   logic [PIXEL_BITS-1:0]  frame_pixels_ff, frame_pixels_in;
   logic [INDEX_BITS-1:0]  item_index_ff;
   logic [GREY_BITS-1:0]   item_grey_ff;
   logic [LEVEL_BITS-1:0]  cur_level_ff, cur_level_in;
   logic [PIXEL_BITS-1:0]  count_ff, count_in;
   logic [PIXEL_BITS-1:0]  remain_ff, remain_in;
   logic [PIXEL_BITS-1:0]  quota_ff, quota_in;
   logic [PIXEL_BITS-1:0]  init_quota_ff, init_quota_in;
   logic [GREY_BITS-1:0]   boundary_ff, boundary_in;
   logic [PIXEL_BITS-1:0]  seen_ff, seen_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [LCOUNT_BITS-1:0] levels_eff;
   logic [PIXEL_BITS-1:0]  pixels_eff;
   logic [PIXEL_BITS-1:0]  remain_sub;
   logic [PIXEL_BITS-1:0]  seen_next;
   logic [LCOUNT_BITS-1:0] levels_next;
   logic                   is_last;
   logic                   take;
   logic                   out_free;
   logic                   frame_end;
   logic                   req_take;
   logic                   csr_take;
   logic                   finish;
   logic                   close;
   div_cmd_type            div_cmd;
   div_rsp_type            div_rsp;

   bglq_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_cmd (div_cmd),
      .div_rsp (div_rsp)
   );

   always_comb begin
      priority if (level_count_ff == '0) begin
         levels_eff = LCOUNT_BITS'(1);
      end else if (level_count_ff > LCOUNT_BITS'(MAX_LEVELS)) begin
         levels_eff = LCOUNT_BITS'(MAX_LEVELS);
      end else begin
         levels_eff = level_count_ff;
      end
      pixels_eff  = (frame_pixels_ff == '0) ? PIXEL_BITS'(1) : frame_pixels_ff;
      levels_next = {1'b0, cur_level_ff} + LCOUNT_BITS'(1);
      is_last     = levels_next >= levels_eff;
      take        = (count_ff < quota_ff) || is_last || (item_grey_ff == boundary_ff);
      remain_sub  = (remain_ff >= count_ff) ? remain_ff - count_ff : '0;
      seen_next   = seen_ff + PIXEL_BITS'(1);
      frame_end   = seen_next >= pixels_eff;
      out_free    = !rsp_valid_ff || !rsp_stall;
      csr_take    = csr_valid && csr_ready;
      req_take    = req_valid && !req_stall;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      if (csr_take) begin
         state_in = ST_CFG_START;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) state_in = ST_EVAL;
            end
            ST_EVAL: begin
               if (!take) state_in = ST_CLOSE_WAIT;
               else if (out_free) state_in = ST_IDLE;
            end
            ST_CLOSE_WAIT: begin
               if (div_rsp.done) state_in = ST_EVAL;
            end
            ST_CFG_START: begin
               state_in = ST_CFG_WAIT;
            end
            ST_CFG_WAIT: begin
               if (div_rsp.done) state_in = ST_IDLE;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   // Sequencer outputs.
   always_comb begin
      req_stall        = 1'b1;
      finish           = 1'b0;
      close            = 1'b0;
      div_cmd.start    = 1'b0;
      div_cmd.dividend = remain_sub;
      div_cmd.divisor  = levels_eff - {1'b0, cur_level_ff};
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_EVAL: begin
            finish        = take && out_free;
            close         = !take;
            div_cmd.start = !take;
         end
         ST_CFG_START: begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = pixels_eff;
            div_cmd.divisor  = levels_eff;
         end
         ST_CLOSE_WAIT, ST_CFG_WAIT: begin
            req_stall = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign csr_ready = 1'b1;

   // Frame state.
   always_comb begin
      level_count_in  = level_count_ff;
      frame_pixels_in = frame_pixels_ff;
      cur_level_in    = cur_level_ff;
      count_in        = count_ff;
      remain_in       = remain_ff;
      quota_in        = quota_ff;
      init_quota_in   = init_quota_ff;
      boundary_in     = boundary_ff;
      seen_in         = seen_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_data_in     = rsp_data_ff;
      if (csr_take) begin
         if (csr_index == CSR_LEVEL_COUNT) level_count_in = csr_data[LCOUNT_BITS-1:0];
         if (csr_index == CSR_FRAME_PIXELS) frame_pixels_in = csr_data;
         cur_level_in = '0;
         count_in     = '0;
         boundary_in  = '0;
         seen_in      = '0;
      end else if (state_ff == ST_CFG_WAIT && div_rsp.done) begin
         init_quota_in = div_rsp.quotient;
         quota_in      = div_rsp.quotient;
         remain_in     = pixels_eff;
      end else if (state_ff == ST_CLOSE_WAIT && div_rsp.done) begin
         quota_in     = div_rsp.quotient;
         cur_level_in = cur_level_ff + LEVEL_BITS'(1);
         count_in     = '0;
      end else if (close) begin
         remain_in = remain_sub;
      end else if (finish) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.out_index   = item_index_ff;
         rsp_data_in.level       = cur_level_ff;
         rsp_data_in.frame_done  = frame_end;
         rsp_data_in.levels_used = levels_next;
         if (frame_end) begin
            cur_level_in = '0;
            count_in     = '0;
            remain_in    = pixels_eff;
            quota_in     = init_quota_ff;
            boundary_in  = '0;
            seen_in      = '0;
         end else begin
            count_in = count_ff + PIXEL_BITS'(1);
            seen_in  = seen_next;
            if ((count_ff < quota_ff) || is_last) boundary_in = item_grey_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         level_count_ff  <= LCOUNT_BITS'(1);
         frame_pixels_ff <= PIXEL_BITS'(1);
         cur_level_ff    <= '0;
         count_ff        <= '0;
         remain_ff       <= PIXEL_BITS'(1);
         quota_ff        <= PIXEL_BITS'(1);
         init_quota_ff   <= PIXEL_BITS'(1);
         boundary_ff     <= '0;
         seen_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         level_count_ff  <= level_count_in;
         frame_pixels_ff <= frame_pixels_in;
         cur_level_ff    <= cur_level_in;
         count_ff        <= count_in;
         remain_ff       <= remain_in;
         quota_ff        <= quota_in;
         init_quota_ff   <= init_quota_in;
         boundary_ff     <= boundary_in;
         seen_ff         <= seen_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      if (req_take) begin
         item_index_ff <= req_data.pixel_index;
         item_grey_ff  <= req_data.grey_value;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_req_to_eval: assert property (@(posedge clock) disable iff (reset)
      (req_take && !csr_take) |=> state_ff == ST_EVAL)
      else $error("accepted pixel did not start evaluation");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> req_stall)
      else $error("input open while sequencer busy");
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      finish |-> {1'b0, cur_level_ff} < levels_eff)
      else $error("level beyond requested level count");
   a_close_not_last: assert property (@(posedge clock) disable iff (reset)
      close |-> !is_last)
      else $error("final level closed");
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      (div_rsp.done && !$past(csr_take)) |->
         (state_ff == ST_CLOSE_WAIT || state_ff == ST_CFG_WAIT))
      else $error("quotient arrived outside a wait state");
`endif

endmodule
